### hw/rtl/fsa_pkg.sv
// shared types, constants and sizes for the fixed slot allocator
package fsa_pkg;

  // zone geometry
  localparam int SLOT_COUNT = 128;
  localparam int SLOT_BYTES = 128;
  localparam int ZONE_SPAN  = SLOT_COUNT * SLOT_BYTES;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OFF_W = (ZONE_SPAN > 1) ? $clog2(ZONE_SPAN) : 1;

  // offset to slot index by reciprocal multiply, exact for offsets below 2**OFF_W
  localparam int DIV_SH    = OFF_W + 8;
  localparam int DIV_RECIP = (2 ** DIV_SH + SLOT_BYTES - 1) / SLOT_BYTES;
  localparam int DIV_PW    = OFF_W + DIV_SH + 1;

  // free slot search, split into groups
  localparam int GROUP_W   = 16;
  localparam int GROUP_N   = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
  localparam int GIDX_W    = $clog2(GROUP_W);
  localparam int SEARCH_W  = GROUP_N * GROUP_W;

  // front to back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [31:0] ZONE_BASE_RST = 32'd4096;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_RESIZE = 2'd3
  } req_kind_e;

  typedef enum logic [2:0] {
    STS_OK     = 3'd0,
    STS_RANGE  = 3'd1,
    STS_ALIGN  = 3'd2,
    STS_FULL   = 3'd3,
    STS_SIZE   = 3'd4,
    STS_UNUSED = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [7:0]  req_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] slot_address;
    logic [7:0]  slot_size;
    logic [7:0]  used_slots;
  } rsp_t;

  // classified request, as it waits for the back end
  typedef struct packed {
    req_kind_e        kind;
    logic [31:0]      address;
    logic [7:0]       size;
    logic             range_bad;
    logic             size_bad;
    logic [IDX_W-1:0] slot;
    logic [OFF_W-1:0] off;
  } item_t;

endpackage

### hw/rtl/fsa_ram.sv
// generic single write port ram with registered read
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fsa_front.sv
// request intake: address range, size and slot index classification
module fsa_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fsa_pkg::req_t req_i,
  input  logic [31:0]   zone_base_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output fsa_pkg::item_t push_item_o
);
  import fsa_pkg::*;

  logic [32:0]       zone_end;
  logic [31:0]       off_full;
  logic [OFF_W-1:0]  off;
  logic [DIV_PW-1:0] div_prod;
  logic              range_bad;
  logic              size_bad;

  // end bound is exclusive and computed without wrap
  assign zone_end  = {1'b0, zone_base_i} + 33'(ZONE_SPAN);
  assign range_bad = (req_i.address == 32'd0) || (req_i.address < zone_base_i) ||
                     ({1'b0, req_i.address} >= zone_end);
  assign size_bad  = (req_i.req_size == 8'd0) || (req_i.req_size > 8'(SLOT_BYTES));

  assign off_full = req_i.address - zone_base_i;
  assign off      = off_full[OFF_W-1:0];
  assign div_prod = DIV_PW'(off) * DIV_PW'(DIV_RECIP);

  always_comb begin
    push_item_o           = '0;
    push_item_o.kind      = req_kind_e'(req_i.req_type);
    push_item_o.address   = req_i.address;
    push_item_o.size      = req_i.req_size;
    push_item_o.range_bad = range_bad;
    push_item_o.size_bad  = size_bad;
    push_item_o.slot      = IDX_W'(div_prod >> DIV_SH);
    push_item_o.off       = off;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

### hw/rtl/fsa_queue.sv
// short fifo between request intake and execution
module fsa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fsa_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fsa_pkg::item_t pop_item_o
);
  import fsa_pkg::*;

  item_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hw/rtl/fsa_back.sv
// request execution: free slot search, size memory update, result register
module fsa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    zone_base_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  fsa_pkg::item_t pop_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fsa_pkg::rsp_t  rsp_o
);
  import fsa_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_EXEC = 2'b10
  } bk_state_e;

  bk_state_e state_q, state_d;
  item_t     item_q;

  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [7:0]            count_q, count_d;
  logic                  out_valid_q;
  rsp_t                  rsp_q, rsp_d;

  // free slot search, first level registered
  logic [SEARCH_W-1:0]   used_pad;
  logic [GROUP_N-1:0]    grp_free_d, grp_free_q;
  logic [GIDX_W-1:0]     grp_idx_d [GROUP_N];
  logic [GIDX_W-1:0]     grp_idx_q [GROUP_N];
  logic                  any_free;
  logic [IDX_W-1:0]      free_idx;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [7:0]            ram_wdata;
  logic [7:0]            ram_rdata;
  logic                  pop;
  logic                  retire;
  logic                  slot_used;
  logic [7:0]            stored_size;
  logic [OFF_W-1:0]      slot_off;
  logic                  align_bad;
  logic [31:0]           alloc_addr;

  always_comb begin
    used_pad                 = '1;
    used_pad[SLOT_COUNT-1:0] = used_q;
  end

  always_comb begin
    for (int g = 0; g < GROUP_N; g++) begin
      grp_free_d[g] = 1'b0;
      grp_idx_d[g]  = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
        if (!used_pad[g * GROUP_W + b]) begin
          grp_free_d[g] = 1'b1;
          grp_idx_d[g]  = GIDX_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_free_q <= grp_free_d;
    grp_idx_q  <= grp_idx_d;
  end

  // second level picks the lowest group with a free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int g = GROUP_N - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(g * GROUP_W + int'(grp_idx_q[g]));
      end
    end
  end

  assign pop_ready_o = (state_q == BK_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign retire      = (state_q == BK_EXEC) && (!out_valid_q || out_ready_i);

  assign slot_used   = used_q[item_q.slot];
  assign stored_size = slot_used ? ram_rdata : 8'd0;
  assign slot_off    = OFF_W'(OFF_W'(item_q.slot) * OFF_W'(SLOT_BYTES));
  assign align_bad   = (slot_off != item_q.off);
  assign alloc_addr  = zone_base_i + 32'(free_idx) * 32'(SLOT_BYTES);

  always_comb begin
    used_d    = used_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_waddr = item_q.slot;
    ram_wdata = item_q.size;
    rsp_d     = '0;
    rsp_d.status = STS_OK;
    unique case (item_q.kind)
      REQ_ALLOC: begin
        if (item_q.size_bad) begin
          rsp_d.status = STS_SIZE;
        end else if (!any_free) begin
          rsp_d.status = STS_FULL;
        end else begin
          used_d[free_idx]   = 1'b1;
          count_d            = count_q + 8'd1;
          ram_we             = retire;
          ram_waddr          = free_idx;
          rsp_d.slot_address = alloc_addr;
        end
      end
      REQ_FREE: begin
        if (item_q.range_bad) begin
          rsp_d.status = STS_RANGE;
        end else if (align_bad) begin
          rsp_d.status = STS_ALIGN;
        end else if (!slot_used) begin
          rsp_d.status = STS_UNUSED;
        end else begin
          used_d[item_q.slot] = 1'b0;
          count_d             = count_q - 8'd1;
        end
      end
      REQ_QUERY: begin
        if (item_q.range_bad) begin
          rsp_d.status = STS_RANGE;
        end else if (align_bad) begin
          rsp_d.status = STS_ALIGN;
        end else begin
          rsp_d.slot_size = stored_size;
        end
      end
      REQ_RESIZE: begin
        if (item_q.range_bad) begin
          rsp_d.status = STS_RANGE;
        end else if (item_q.size_bad) begin
          rsp_d.status = STS_SIZE;
        end else if (align_bad) begin
          rsp_d.status = STS_ALIGN;
        end else if (!slot_used) begin
          rsp_d.status = STS_UNUSED;
        end else begin
          ram_we             = retire;
          rsp_d.slot_address = item_q.address;
        end
      end
      default: begin
        rsp_d.status = STS_OK;
      end
    endcase
    rsp_d.used_slots = count_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (retire) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (retire) begin
        used_q      <= used_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q <= pop_item_i;
    end
    if (retire) begin
      rsp_q <= rsp_d;
    end
  end

  fsa_ram #(
    .WIDTH(8),
    .DEPTH(SLOT_COUNT)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (pop),
    .raddr_i(pop_item_i.slot),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### hw/rtl/fixed_slot_allocator.sv
// top level of the fixed slot allocator: apb register, intake, queue and execution
//
// Fixed slot allocator. The zone holds SLOT_COUNT slots of SLOT_BYTES bytes starting at
// zone_base (apb register at every address, reset 4096). Each request (alloc, free, size
// query, resize) gives exactly one response carrying a status code, the slot address, the
// stored size and the number of used slots after the request. Requests are classified on
// intake (null, range and size checks, slot index) and wait in a two-entry queue. The
// execution side has two states. In the idle state it pops a request, reads the size
// memory and registers the first level of the free slot search; in the execute state it
// resolves the status, writes the size memory and loads the response register. It takes
// no new request from the queue until the current one has retired.
// A response waiting in its register does not block intake; the execution side stalls only
// when a new response is ready while the previous one has not been taken. Slot occupancy
// lives in flip-flops cleared by reset, so the block is ready right after reset with no
// clearing pass. zone_base may only be written while the block is idle.
module fixed_slot_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,

  // request channel
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fsa_pkg::req_t req_i,

  // response channel
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fsa_pkg::rsp_t rsp_o,

  // apb configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import fsa_pkg::*;

  logic [31:0] zone_base_q;
  logic        cfg_write;

  logic        push_valid, push_ready;
  item_t       push_item;
  logic        pop_valid, pop_ready;
  item_t       pop_item;

  // single register, so every word offset lands on zone_base
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[1:0] == paddr);
  assign prdata    = zone_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_base_q <= ZONE_BASE_RST;
    end else if (cfg_write) begin
      zone_base_q <= pwdata;
    end
  end

  // intake: classify the request on acceptance
  fsa_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req_i),
    .zone_base_i (zone_base_q),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  // decouples intake from execution
  fsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  // execution: slot search, size memory, response register
  fsa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .zone_base_i(zone_base_q),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_item_i (pop_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rsp_o      (rsp_o)
  );

endmodule
